// ----- hdl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // Default heap size in bytes.
    localparam int HEAP_BYTES_DEFAULT = 65536;

    // Width of walk pointers and block sizes. Merged sizes and pointer sums
    // may pass 16 bits before the range checks see them.
    localparam int PW = 18;

    localparam logic [15:0] SPLIT_THR_RESET = 16'd64;

    // Byte address of the split threshold register.
    localparam logic [1:0] ADDR_SPLIT_THR = 2'd0;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REL_RD,
        S_REL_CHK,
        S_ALC_CHK,
        S_ALC_RD,
        S_ALC_HDR,
        S_ALC_SPLIT,
        S_ALC_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr_step;   // write one word of the clearing pass
        logic    load;       // capture a new word and rewind the walk
        logic    rd_walk;    // read the header at the walk pointer
        logic    step_used;  // skip a used block
        logic    step_free;  // free block too small: merge and move on
        logic    wr_fit;     // write the header of the allocated block
        logic    wr_split;   // write the header of the split-off remainder
        logic    rd_rel;     // read the header of the block to release
        logic    wr_rel;     // clear the used bit of that header
        logic    finish;     // present a result
        logic    fin_addr;   // result carries the allocated address
        status_t fin_status;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic req_ovf;
        logic p_oob;
        logic hdr_end;
        logic hdr_used;
        logic fit;
        logic split;
        logic rel_bad;
    } dp_stat_t;

endpackage

// ----- hdl/ffha_cfg.sv -----
// ----------------------------------------------------------------------------
// ffha_cfg
// APB register port holding the split threshold.
// ----------------------------------------------------------------------------
module ffha_cfg
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] split_threshold
);

    logic [15:0] split_thr_reg;
    logic [15:0] split_thr_next;

    always_comb
    begin
        split_thr_next = split_thr_reg;
        if (psel && penable && pwrite && (paddr == ADDR_SPLIT_THR))
        begin
            split_thr_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_thr_reg <= SPLIT_THR_RESET;
        end
        else
        begin
            split_thr_reg <= split_thr_next;
        end
    end

    assign prdata          = (paddr == ADDR_SPLIT_THR) ? {16'd0, split_thr_reg} : 32'd0;
    assign pready          = 1'b1;
    assign split_threshold = split_thr_reg;

endmodule

// ----- hdl/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: heap memory, walk pointers, size arithmetic and result registers.
// ----------------------------------------------------------------------------
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [15:0] request_bytes,
    input  logic [15:0] release_address,
    input  logic [15:0] split_threshold,
    output logic        done,
    output logic [15:0] payload_address,
    output logic [1:0]  status
);

    localparam int WORDS = HEAP_BYTES / 2;
    localparam int AW    = $clog2(WORDS);
    localparam logic [PW-1:0] HEAP_END  = PW'(HEAP_BYTES);
    localparam logic [15:0]   HEAP_INIT = 16'(HEAP_BYTES - 2);
    localparam logic [AW-1:0] LAST_IDX  = AW'(WORDS - 1);

    logic [15:0]   mem [WORDS];
    logic [15:0]   rdata_reg;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] prev_size_reg, prev_size_next;
    logic          have_prev_reg, have_prev_next;
    logic [16:0]   needed_reg, needed_next;
    logic [15:0]   rel_addr_reg, rel_addr_next;
    logic [15:0]   res_addr_reg, res_addr_next;
    logic [PW-1:0] split_addr_reg, split_addr_next;
    logic [15:0]   rest_reg, rest_next;
    logic          done_reg, done_next;
    logic [15:0]   paddr_out_reg, paddr_out_next;
    status_t       status_reg, status_next;

    logic [15:0]   hdr_size;
    logic [PW-1:0] size_ext;
    logic [PW-1:0] msize;
    logic [PW-1:0] mp;
    logic [PW-1:0] needed_ext;
    logic [PW-1:0] rest;
    logic          fit;
    logic          split;
    logic [15:0]   final_hdr;
    logic [16:0]   needed_calc;
    logic [PW-1:0] rel_hdr;

    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [AW-1:0] wr_idx;
    logic [15:0]   wr_data;

    // Size of the current block, merged with a free block just before it.
    assign hdr_size   = {rdata_reg[15:1], 1'b0};
    assign size_ext   = PW'(hdr_size);
    assign msize      = have_prev_reg ? (size_ext + prev_size_reg) : size_ext;
    assign mp         = have_prev_reg ? prev_reg : p_reg;
    assign needed_ext = PW'(needed_reg);
    assign fit        = (msize >= needed_ext);
    assign rest       = msize - needed_ext;
    // A zero remainder is never split off, whatever the threshold.
    assign split      = (rest >= PW'(split_threshold)) && (rest >= PW'(2));
    assign final_hdr  = (split ? needed_reg[15:0] : msize[15:0]) | 16'h0001;

    assign needed_calc = ({1'b0, request_bytes} + 17'd3) & 17'h1FFFE;
    assign rel_hdr     = PW'(rel_addr_reg) - PW'(2);

    always_comb
    begin
        stat.clr_last = (clr_cnt_reg == LAST_IDX);
        stat.req_ovf  = needed_reg[16];
        stat.p_oob    = (p_reg >= HEAP_END);
        stat.hdr_end  = (hdr_size == 16'd0);
        stat.hdr_used = rdata_reg[0];
        stat.fit      = fit;
        stat.split    = split;
        stat.rel_bad  = rel_addr_reg[0] || (rel_addr_reg < 16'd2) || (rel_hdr >= HEAP_END);
    end

    // Memory port selection.
    always_comb
    begin
        rd_en   = cmd.rd_walk || cmd.rd_rel;
        rd_addr = cmd.rd_rel ? rel_hdr : p_reg;

        wr_addr = mp;
        wr_data = final_hdr;
        priority if (cmd.wr_split)
        begin
            wr_addr = split_addr_reg;
            wr_data = rest_reg;
        end
        else if (cmd.wr_rel)
        begin
            wr_addr = rel_hdr;
            wr_data = {rdata_reg[15:1], 1'b0};
        end
        else if (cmd.step_free)
        begin
            wr_data = msize[15:0];
        end
        else
        begin
            wr_addr = mp;
            wr_data = final_hdr;
        end

        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_cnt_reg;
            wr_data = (clr_cnt_reg == '0) ? HEAP_INIT : 16'd0;
        end
        else
        begin
            wr_en  = (cmd.wr_split || cmd.wr_rel || cmd.wr_fit ||
                      (cmd.step_free && have_prev_reg)) && (wr_addr < HEAP_END);
            wr_idx = wr_addr[AW:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr[AW:1]];
        end
    end

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        have_prev_next  = have_prev_reg;
        needed_next     = needed_reg;
        rel_addr_next   = rel_addr_reg;
        res_addr_next   = res_addr_reg;
        split_addr_next = split_addr_reg;
        rest_next       = rest_reg;
        done_next       = 1'b0;
        paddr_out_next  = paddr_out_reg;
        status_next     = status_reg;

        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        if (cmd.load)
        begin
            p_next         = '0;
            have_prev_next = 1'b0;
            needed_next    = needed_calc;
            rel_addr_next  = release_address;
        end
        if (cmd.step_used)
        begin
            p_next         = p_reg + size_ext;
            have_prev_next = 1'b0;
        end
        if (cmd.step_free)
        begin
            prev_next      = mp;
            prev_size_next = msize;
            have_prev_next = 1'b1;
            p_next         = mp + msize;
        end
        if (cmd.wr_fit)
        begin
            res_addr_next   = mp[15:0] + 16'd2;
            split_addr_next = mp + needed_ext;
            rest_next       = rest[15:0];
        end
        if (cmd.finish)
        begin
            done_next      = 1'b1;
            paddr_out_next = cmd.fin_addr ? res_addr_reg : 16'd0;
            status_next    = cmd.fin_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            have_prev_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            have_prev_reg <= have_prev_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        needed_reg     <= needed_next;
        rel_addr_reg   <= rel_addr_next;
        res_addr_reg   <= res_addr_next;
        split_addr_reg <= split_addr_next;
        rest_reg       <= rest_next;
        paddr_out_reg  <= paddr_out_next;
        status_reg     <= status_next;
    end

    assign done            = done_reg;
    assign payload_address = paddr_out_reg;
    assign status          = status_reg;

endmodule

// ----- hdl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences the clearing pass, the header walk and release.
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     operation,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (operation == OP_RELEASE) ? S_REL_RD : S_ALC_CHK;
                end
            end
            S_REL_RD:
            begin
                state_next = stat.rel_bad ? S_IDLE : S_REL_CHK;
            end
            S_REL_CHK:
            begin
                state_next = S_IDLE;
            end
            S_ALC_CHK:
            begin
                state_next = stat.req_ovf ? S_IDLE : S_ALC_RD;
            end
            S_ALC_RD:
            begin
                state_next = stat.p_oob ? S_IDLE : S_ALC_HDR;
            end
            S_ALC_HDR:
            begin
                priority if (stat.hdr_end)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.hdr_used || !stat.fit)
                begin
                    state_next = S_ALC_RD;
                end
                else
                begin
                    state_next = stat.split ? S_ALC_SPLIT : S_ALC_DONE;
                end
            end
            S_ALC_SPLIT:
            begin
                state_next = S_ALC_DONE;
            end
            S_ALC_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.fin_status = ST_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_REL_RD:
            begin
                if (stat.rel_bad)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_BAD_FREE;
                end
                else
                begin
                    cmd.rd_rel = 1'b1;
                end
            end
            S_REL_CHK:
            begin
                cmd.finish     = 1'b1;
                cmd.wr_rel     = stat.hdr_used;
                cmd.fin_status = stat.hdr_used ? ST_OK : ST_BAD_FREE;
            end
            S_ALC_CHK:
            begin
                if (stat.req_ovf)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NO_SPACE;
                end
            end
            S_ALC_RD:
            begin
                if (stat.p_oob)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NO_SPACE;
                end
                else
                begin
                    cmd.rd_walk = 1'b1;
                end
            end
            S_ALC_HDR:
            begin
                priority if (stat.hdr_end)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NO_SPACE;
                end
                else if (stat.hdr_used)
                begin
                    cmd.step_used = 1'b1;
                end
                else if (!stat.fit)
                begin
                    cmd.step_free = 1'b1;
                end
                else
                begin
                    cmd.wr_fit = 1'b1;
                end
            end
            S_ALC_SPLIT:
            begin
                cmd.wr_split = 1'b1;
            end
            S_ALC_DONE:
            begin
                cmd.finish   = 1'b1;
                cmd.fin_addr = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- hdl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with free-block merging on the header walk.
//
//   channel   handshake                 word
//   request   start & !busy             operation, request_bytes,
//                                       release_address
//   result    done (one cycle)          payload_address, status
//   config    psel & penable & pwrite   split_threshold at byte address 0
//
// After reset a clearing pass writes every heap word with busy high;
// configuration writes are taken during it.
// A release reads the header of its block and clears the used bit; an
// address that fails the range checks is rejected before the header read.
// An allocate checks the rounded size for overflow, then walks the block
// headers (one memory read and one evaluation per header), writes the
// fitting header, and writes the remainder's header when a block is split.
// Fragmentation sets the walk length.
// The result is shown for one cycle and cannot be stalled; busy is low while
// done is high, so the next word may be accepted in that cycle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] request_bytes,
    input  logic [15:0] release_address,
    output logic        done,
    output logic [15:0] payload_address,
    output logic [1:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [15:0] split_threshold;

    ffha_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .split_threshold (split_threshold)
    );

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    ffha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .split_threshold (split_threshold),
        .done            (done),
        .payload_address (payload_address),
        .status          (status)
    );

    // A result always lands in a cycle where the next word can be taken.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result presented while busy");

    // Only a successful allocate carries an address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (payload_address == 16'd0))
        else $error("failed request returned an address");

    // An accepted word keeps the block busy until its result.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // Payload addresses follow a two-byte header and stay even.
    a_addr_even: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !payload_address[0])
        else $error("odd payload address");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator. A short table of
// requests covers reset, size overflow, exact fits, merging and bad
// releases; random phases under several split thresholds follow. Each
// accepted word is run through a behavioral copy of the heap, and every
// result is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
    import ffha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 4;
    localparam int HEAP_BYTES    = HEAP_BYTES_DEFAULT;
    localparam int HEAP_WORDS    = HEAP_BYTES / 2;
    localparam int PHASE_WORDS   = 260;
    localparam int N_PHASES      = 5;
    localparam int N_DIRECTED    = 24;
    localparam int TIMEOUT_NS    = 200_000_000;

    typedef struct packed {
        logic [15:0] addr;
        status_t     st;
    } heap_result_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] req;
        logic [15:0] rel;
        logic        typed;
        logic [15:0] addr;
        status_t     st;
    } heap_request_t;

    // Rows marked typed carry a result read straight off the heap layout;
    // the rest are checked against the heap model.
    localparam heap_request_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{OP_ALLOC,   16'd0,     16'd0,     1'b1, 16'd2, ST_OK},
        '{OP_ALLOC,   16'd65535, 16'd0,     1'b1, 16'd0, ST_NO_SPACE},
        '{OP_ALLOC,   16'd65533, 16'd0,     1'b1, 16'd0, ST_NO_SPACE},
        '{OP_ALLOC,   16'd65532, 16'd0,     1'b1, 16'd0, ST_NO_SPACE},
        '{OP_RELEASE, 16'd0,     16'd1,     1'b1, 16'd0, ST_BAD_FREE},
        '{OP_RELEASE, 16'd0,     16'd0,     1'b1, 16'd0, ST_BAD_FREE},
        '{OP_RELEASE, 16'd0,     16'd65535, 1'b1, 16'd0, ST_BAD_FREE},
        '{OP_RELEASE, 16'd0,     16'd2,     1'b1, 16'd0, ST_OK},
        '{OP_RELEASE, 16'd0,     16'd2,     1'b1, 16'd0, ST_BAD_FREE},
        '{OP_ALLOC,   16'd65532, 16'd0,     1'b1, 16'd2, ST_OK},
        '{OP_ALLOC,   16'd0,     16'd0,     1'b1, 16'd0, ST_NO_SPACE},
        '{OP_RELEASE, 16'd0,     16'd65534, 1'b1, 16'd0, ST_BAD_FREE},
        '{OP_RELEASE, 16'd0,     16'd4,     1'b1, 16'd0, ST_BAD_FREE},
        '{OP_RELEASE, 16'd0,     16'd2,     1'b1, 16'd0, ST_OK},
        '{OP_ALLOC,   16'd100,   16'd0,     1'b0, 16'd0, ST_OK},
        '{OP_ALLOC,   16'd1,     16'd0,     1'b0, 16'd0, ST_OK},
        '{OP_ALLOC,   16'd40,    16'd0,     1'b0, 16'd0, ST_OK},
        '{OP_ALLOC,   16'd65400, 16'd0,     1'b0, 16'd0, ST_OK},
        '{OP_RELEASE, 16'd0,     16'd104,   1'b0, 16'd0, ST_OK},
        '{OP_RELEASE, 16'd0,     16'd2,     1'b0, 16'd0, ST_OK},
        '{OP_ALLOC,   16'd104,   16'd0,     1'b0, 16'd0, ST_OK},
        '{OP_ALLOC,   16'd0,     16'd0,     1'b0, 16'd0, ST_OK},
        '{OP_RELEASE, 16'd0,     16'd108,   1'b0, 16'd0, ST_OK},
        '{OP_RELEASE, 16'd0,     16'd150,   1'b0, 16'd0, ST_OK}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
    logic        done;
    logic [15:0] payload_address;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Behavioral copy of the heap and of the split threshold.
    logic [15:0]  model_heap [0:HEAP_WORDS-1];
    logic [15:0]  model_thr;

    heap_result_t pending_results [$];
    logic [15:0]  live_blocks [$];
    logic [15:0]  last_freed;
    bit           no_idle;
    int           error_count;

    first_fit_heap_allocator #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .done            (done),
        .payload_address (payload_address),
        .status          (status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic logic [15:0] heap_word(int unsigned byte_addr);
        return ((byte_addr >> 1) < HEAP_WORDS) ? model_heap[byte_addr >> 1] : 16'h0000;
    endfunction

    function automatic void heap_store(int unsigned byte_addr, int unsigned value);
        if ((byte_addr >> 1) < HEAP_WORDS)
        begin
            model_heap[byte_addr >> 1] = value[15:0];
        end
    endfunction

    // First-fit walk; a free block right after another free block is folded
    // into it and the merged block is tried again.
    function automatic heap_result_t first_fit_alloc(logic [15:0] req);
        int unsigned  needed;
        int unsigned  p;
        int unsigned  prev;
        int unsigned  size;
        int unsigned  rest;
        bit           merge_pending;
        logic [15:0]  hdr;
        heap_result_t res;
        res.addr      = 16'd0;
        res.st        = ST_NO_SPACE;
        needed        = req;
        needed        = (needed + 3) & 32'h1FFFE;
        p             = 0;
        prev          = 0;
        merge_pending = 1'b0;
        if (needed > 32'hFFFF)
        begin
            return res;
        end
        while (p < HEAP_BYTES)
        begin
            hdr  = heap_word(p);
            size = {hdr[15:1], 1'b0};
            if (size == 0)
            begin
                break;
            end
            if (!hdr[0])
            begin
                if (merge_pending)
                begin
                    size += {heap_word(prev) & 16'hFFFE};
                    p = prev;
                    heap_store(p, size);
                    merge_pending = 1'b0;
                end
                if (size >= needed)
                begin
                    rest = size - needed;
                    // A zero leftover is never split off, whatever the threshold.
                    if (rest >= model_thr && rest >= 2)
                    begin
                        heap_store(p, needed);
                        heap_store(p + needed, rest);
                    end
                    heap_store(p, heap_word(p) | 16'h0001);
                    res.addr = 16'(p + 2);
                    res.st   = ST_OK;
                    return res;
                end
                prev          = p;
                merge_pending = 1'b1;
            end
            else
            begin
                merge_pending = 1'b0;
            end
            p += size;
        end
        return res;
    endfunction

    function automatic heap_result_t release_block(logic [15:0] payload);
        int unsigned  hdr_at;
        logic [15:0]  hdr;
        heap_result_t res;
        res.addr = 16'd0;
        res.st   = ST_BAD_FREE;
        if (payload[0] || payload < 16'd2)
        begin
            return res;
        end
        hdr_at = payload - 16'd2;
        if (hdr_at >= HEAP_BYTES)
        begin
            return res;
        end
        hdr = heap_word(hdr_at);
        if (!hdr[0])
        begin
            return res;
        end
        heap_store(hdr_at, {hdr[15:1], 1'b0});
        res.st = ST_OK;
        return res;
    endfunction

    // Drives one word, waits for it to be taken and queues its expectation.
    task automatic send_word(op_t op, logic [15:0] req, logic [15:0] rel,
                             logic typed, heap_result_t typed_res);
        int           gap;
        int           i;
        heap_result_t pred;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 6);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        operation       <= op;
        request_bytes   <= req;
        release_address <= rel;
        do @(posedge clk); while (busy !== 1'b0);
        pred = (op == OP_ALLOC) ? first_fit_alloc(req) : release_block(rel);
        pending_results.push_back(typed ? typed_res : pred);
        if (pred.st == ST_OK && op == OP_ALLOC)
        begin
            live_blocks.push_back(pred.addr);
        end
        else if (pred.st == ST_OK)
        begin
            last_freed = rel;
            for (i = 0; i < live_blocks.size(); i++)
            begin
                if (live_blocks[i] == rel)
                begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic set_split_threshold(logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SPLIT_THR;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        model_thr = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata[15:0] !== value)
        begin
            $display("%0t: split threshold read back expected %h actual %h",
                     $time, value, prdata[15:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, address %h status %0d",
                         $time, payload_address, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (payload_address !== want.addr)
                begin
                    $display("%0t: payload_address expected %h actual %h",
                             $time, want.addr, payload_address);
                    error_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [15:0]  thresholds [0:N_PHASES-1];
        heap_result_t typed_res;
        heap_request_t row;
        op_t          op;
        logic [15:0]  req;
        logic [15:0]  rel;
        int           roll;
        int           k;

        rst_n           <= 1'b0;
        start           <= 1'b0;
        operation       <= OP_ALLOC;
        request_bytes   <= 16'd0;
        release_address <= 16'd0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= ADDR_SPLIT_THR;
        pwdata          <= 32'd0;
        error_count = 0;
        no_idle     = 1'b0;
        last_freed  = 16'd2;
        foreach (model_heap[i])
        begin
            model_heap[i] = 16'd0;
        end
        model_heap[0] = 16'(HEAP_BYTES - 2);
        model_thr     = SPLIT_THR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
        begin
            row            = DIRECTED_ROWS[k];
            typed_res.addr = row.addr;
            typed_res.st   = row.st;
            send_word(row.op, row.req, row.rel, row.typed, typed_res);
        end

        thresholds[0] = 16'd2;
        thresholds[1] = 16'd65534;
        thresholds[2] = 16'd0;
        thresholds[3] = SPLIT_THR_RESET;
        thresholds[4] = 16'($urandom_range(2, 2000));
        typed_res = '0;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge clk);
            set_split_threshold(thresholds[ph]);
            // One phase runs back to back with no idle cycles at all.
            no_idle = (ph == 3);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                roll = $urandom_range(0, 99);
                req  = 16'($urandom());
                rel  = 16'($urandom());
                op   = OP_ALLOC;
                if (roll < 8)
                begin
                    op = op_t'($urandom_range(0, 1));
                end
                else if (roll < 13)
                begin
                    op = OP_RELEASE;
                    case ($urandom_range(0, 2))
                        0: rel = last_freed;
                        1: rel = rel | 16'h0001;
                        default: rel = rel & 16'hFFFE;
                    endcase
                end
                else if (live_blocks.size() != 0 &&
                         $urandom_range(0, 99) >= (live_blocks.size() < 24 ? 65 : 35))
                begin
                    op  = OP_RELEASE;
                    rel = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10)
                        req = 16'd0;
                    else if (roll < 75)
                        req = 16'($urandom_range(1, 300));
                    else if (roll < 93)
                        req = 16'($urandom_range(301, 4000));
                    else if (roll < 97)
                        req = 16'($urandom_range(4001, 65535));
                    else
                        req = 16'($urandom_range(65530, 65535));
                end
                send_word(op, req, rel, 1'b0, typed_res);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (32) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
